// ----- rtl/smlp_pkg.sv -----
// Package for the symbol map line parser: payload structs, result codes
// and character constants. No dependencies.
`default_nettype none

package smlp_pkg;

	localparam int unsigned MAX_NAME_LEN = 128;

	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_FINISH = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_SYNTAX   = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       end_of_file;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  character;
		logic [15:0] address;
		err_t        error_kind;
		logic        last;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/symbol_map_line_parser.sv -----
// A byte is registered in stage 1 at acceptance and its first result in the output
// register when the byte leaves stage 1. Throughput: one byte per cycle while the output
// is not stalled; a byte that gives two results holds the input while its second result
// waits in the pending register. Reset (arst_n low, asynchronous): parser returns to line
// start, name length and address clear, and both pipeline stages empty.
// Depends on smlp_pkg.
`default_nettype none

module symbol_map_line_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire smlp_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output smlp_pkg::rsp_t     rsp
);

	typedef enum logic [7:0] {
		PH_LINE   = 8'b0000_0001,
		PH_IDENT  = 8'b0000_0010,
		PH_BLANK  = 8'b0000_0100,
		PH_SPACE  = 8'b0000_1000,
		PH_DOLLAR = 8'b0001_0000,
		PH_HEX    = 8'b0010_0000,
		PH_REST   = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [7:0]      name_len_q, name_len_d;
	logic [15:0]     addr_q, addr_d;

	logic            valid_s1;
	smlp_pkg::req_t  req_s1;

	logic            rsp_valid_q;
	smlp_pkg::rsp_t  rsp_q;
	logic            pend_valid_q;
	smlp_pkg::rsp_t  pend_q;

	smlp_pkg::rsp_t  res0, res1;
	logic [1:0]      n_res;
	logic            advance;
	logic            out_free;

	logic [7:0]      c;
	logic            eof;
	logic            is_ident;
	logic            is_hex;
	logic [3:0]      hex_digit;

	assign c   = req_s1.byte_req;
	assign eof = req_s1.end_of_file;

	always_comb begin
		is_ident = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
		           ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h5F);
		is_hex    = 1'b1;
		hex_digit = 4'd0;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			hex_digit = c[3:0];
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			hex_digit = 4'(c - 8'h61) + smlp_pkg::HEX_ALPHA_BASE;
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			hex_digit = 4'(c - 8'h41) + smlp_pkg::HEX_ALPHA_BASE;
		end else begin
			is_hex = 1'b0;
		end
	end

	// Next state and up to two results for the byte held in stage 1.
	always_comb begin
		phase_d    = phase_q;
		name_len_d = name_len_q;
		addr_d     = addr_q;
		n_res      = 2'd0;
		res0       = '{kind: smlp_pkg::KIND_CHAR, character: 8'd0, address: 16'd0,
		               error_kind: smlp_pkg::ERR_NONE, last: 1'b0};
		res1       = res0;
		unique case (phase_q)
			PH_LINE: begin
				if (eof || !is_ident) begin
					res0.kind = smlp_pkg::KIND_FINISH;
					n_res     = 2'd1;
					phase_d   = PH_DONE;
				end else begin
					res0.character = smlp_pkg::CH_AT;
					res1.character = c;
					n_res          = 2'd2;
					name_len_d     = 8'd2;
					phase_d        = PH_IDENT;
				end
			end
			PH_IDENT, PH_BLANK: begin
				if ((phase_q == PH_IDENT) && !eof && is_ident) begin
					if (32'(name_len_q) >= smlp_pkg::MAX_NAME_LEN) begin
						res0.kind       = smlp_pkg::KIND_ERROR;
						res0.error_kind = smlp_pkg::ERR_TOO_LONG;
						n_res           = 2'd1;
						phase_d         = PH_DONE;
					end else begin
						res0.character = c;
						n_res          = 2'd1;
						name_len_d     = name_len_q + 8'd1;
					end
				end else if (!eof && ((c == smlp_pkg::CH_SPACE) || (c == smlp_pkg::CH_TAB))) begin
					phase_d = PH_BLANK;
				end else if (!eof && (c == smlp_pkg::CH_EQUAL)) begin
					phase_d = PH_SPACE;
				end else begin
					res0.kind       = smlp_pkg::KIND_ERROR;
					res0.error_kind = smlp_pkg::ERR_SYNTAX;
					n_res           = 2'd1;
					phase_d         = PH_DONE;
				end
			end
			PH_SPACE: begin
				if (!eof && (c == smlp_pkg::CH_SPACE)) begin
					phase_d = PH_DOLLAR;
				end else begin
					res0.kind       = smlp_pkg::KIND_ERROR;
					res0.error_kind = smlp_pkg::ERR_SYNTAX;
					n_res           = 2'd1;
					phase_d         = PH_DONE;
				end
			end
			PH_DOLLAR: begin
				if (!eof && (c == smlp_pkg::CH_DOLLAR)) begin
					addr_d  = 16'd0;
					phase_d = PH_HEX;
				end else begin
					res0.kind       = smlp_pkg::KIND_ERROR;
					res0.error_kind = smlp_pkg::ERR_SYNTAX;
					n_res           = 2'd1;
					phase_d         = PH_DONE;
				end
			end
			PH_HEX, PH_REST: begin
				if ((phase_q == PH_HEX) && !eof && is_hex) begin
					addr_d = {addr_q[11:0], hex_digit};
				end else if (eof) begin
					res0.kind    = smlp_pkg::KIND_RECORD;
					res0.address = addr_q;
					res1.kind    = smlp_pkg::KIND_FINISH;
					n_res        = 2'd2;
					phase_d      = PH_DONE;
				end else if (c == smlp_pkg::CH_LF) begin
					res0.kind    = smlp_pkg::KIND_RECORD;
					res0.address = addr_q;
					n_res        = 2'd1;
					phase_d      = PH_LINE;
				end else begin
					phase_d = PH_REST;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	// A byte leaves stage 1 only when both of its possible results fit.
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign advance   = valid_s1 && out_free && !pend_valid_q;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			req_s1   <= '0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
			if (req_valid) begin
				req_s1 <= req;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LINE;
			name_len_q <= 8'd0;
			addr_q     <= 16'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			name_len_q <= name_len_d;
			addr_q     <= addr_d;
		end
	end

	// The second result of a byte waits in a pending register behind the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
		end else if (advance) begin
			if (n_res != 2'd0) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res0;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (n_res == 2'd2) begin
				pend_valid_q <= 1'b1;
				pend_q       <= res1;
			end
		end else if (pend_valid_q && out_free) begin
			rsp_valid_q  <= 1'b1;
			rsp_q        <= pend_q;
			pend_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- sim/tb_symbol_map_line_parser.sv -----
// Self-checking testbench for symbol_map_line_parser: a scoreboard class predicts
// the result beats of each accepted text byte and checks them in order.
// Depends on smlp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_symbol_map_line_parser;

	localparam int TEXT_BYTES   = 1420;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AFTER   = 600;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	// Predicts the parser's result beats and checks the ones that come out.
	class map_scoreboard;
		typedef enum {AT_LINE_START, IN_NAME, IN_BLANKS, WANT_SPACE, WANT_DOLLAR,
			IN_HEX, IN_REST, STOPPED} parse_phase_t;

		parse_phase_t phase;
		int name_len;
		logic [15:0] address;
		smlp_pkg::rsp_t owed[$];
		int fails;
		int results_checked;
		int records_checked;

		function new();
			phase = AT_LINE_START;
			name_len = 0;
			address = '0;
			fails = 0;
			results_checked = 0;
			records_checked = 0;
		endfunction

		static function bit is_name_char(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
				(c >= "0" && c <= "9") || c == "_";
		endfunction

		static function int hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return c - "0";
			if (c >= "a" && c <= "f")
				return c - "a" + smlp_pkg::HEX_ALPHA_BASE;
			if (c >= "A" && c <= "F")
				return c - "A" + smlp_pkg::HEX_ALPHA_BASE;
			return -1;
		endfunction

		function void owe(smlp_pkg::kind_t k, logic [7:0] ch, logic [15:0] addr,
			smlp_pkg::err_t e);
			smlp_pkg::rsp_t r;
			r.kind = k;
			r.character = ch;
			r.address = addr;
			r.error_kind = e;
			r.last = 1'b0;
			owed.push_back(r);
		endfunction

		// Advances the parse state by one accepted byte and queues its results.
		function void note_byte(smlp_pkg::req_t b);
			int before_count;
			int d;
			logic [7:0] c;
			before_count = owed.size();
			c = b.byte_req;
			case (phase)
			AT_LINE_START: begin
				if (b.end_of_file || !is_name_char(c)) begin
					owe(smlp_pkg::KIND_FINISH, 8'h00, 16'h0000, smlp_pkg::ERR_NONE);
					phase = STOPPED;
				end else begin
					owe(smlp_pkg::KIND_CHAR, smlp_pkg::CH_AT, 16'h0000, smlp_pkg::ERR_NONE);
					owe(smlp_pkg::KIND_CHAR, c, 16'h0000, smlp_pkg::ERR_NONE);
					name_len = 2;
					phase = IN_NAME;
				end
			end
			IN_NAME, IN_BLANKS: begin
				if (phase == IN_NAME && !b.end_of_file && is_name_char(c)) begin
					if (name_len >= smlp_pkg::MAX_NAME_LEN) begin
						owe(smlp_pkg::KIND_ERROR, 8'h00, 16'h0000, smlp_pkg::ERR_TOO_LONG);
						phase = STOPPED;
					end else begin
						owe(smlp_pkg::KIND_CHAR, c, 16'h0000, smlp_pkg::ERR_NONE);
						name_len++;
					end
				end else if (!b.end_of_file &&
					(c == smlp_pkg::CH_SPACE || c == smlp_pkg::CH_TAB)) begin
					phase = IN_BLANKS;
				end else if (!b.end_of_file && c == smlp_pkg::CH_EQUAL) begin
					phase = WANT_SPACE;
				end else begin
					owe(smlp_pkg::KIND_ERROR, 8'h00, 16'h0000, smlp_pkg::ERR_SYNTAX);
					phase = STOPPED;
				end
			end
			WANT_SPACE: begin
				if (!b.end_of_file && c == smlp_pkg::CH_SPACE) begin
					phase = WANT_DOLLAR;
				end else begin
					owe(smlp_pkg::KIND_ERROR, 8'h00, 16'h0000, smlp_pkg::ERR_SYNTAX);
					phase = STOPPED;
				end
			end
			WANT_DOLLAR: begin
				if (!b.end_of_file && c == smlp_pkg::CH_DOLLAR) begin
					address = '0;
					phase = IN_HEX;
				end else begin
					owe(smlp_pkg::KIND_ERROR, 8'h00, 16'h0000, smlp_pkg::ERR_SYNTAX);
					phase = STOPPED;
				end
			end
			IN_HEX, IN_REST: begin
				d = b.end_of_file ? -1 : hex_digit(c);
				if (phase == IN_HEX && d >= 0) begin
					address = {address[11:0], d[3:0]};
				end else if (b.end_of_file) begin
					owe(smlp_pkg::KIND_RECORD, 8'h00, address, smlp_pkg::ERR_NONE);
					owe(smlp_pkg::KIND_FINISH, 8'h00, 16'h0000, smlp_pkg::ERR_NONE);
					phase = STOPPED;
				end else if (c == smlp_pkg::CH_LF) begin
					owe(smlp_pkg::KIND_RECORD, 8'h00, address, smlp_pkg::ERR_NONE);
					phase = AT_LINE_START;
				end else begin
					phase = IN_REST;
				end
			end
			default: begin
				phase = STOPPED;
			end
			endcase
			if (owed.size() > before_count)
				owed[owed.size() - 1].last = 1'b1;
		endfunction

		function string describe(smlp_pkg::rsp_t r);
			return $sformatf("kind=%0d char=%02h addr=%04h err=%0d last=%0b",
				r.kind, r.character, r.address, r.error_kind, r.last);
		endfunction

		function void flag(string msg);
			fails++;
			if (fails <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void check_result(smlp_pkg::rsp_t got);
			smlp_pkg::rsp_t want;
			results_checked++;
			if (owed.size() == 0) begin
				flag($sformatf("result %0d with nothing owed: %s", results_checked,
					describe(got)));
				return;
			end
			want = owed.pop_front();
			if (got.kind !== want.kind || got.character !== want.character ||
				got.address !== want.address || got.error_kind !== want.error_kind ||
				got.last !== want.last)
				flag($sformatf("result %0d expected %s, got %s", results_checked,
					describe(want), describe(got)));
			else if (got.kind == smlp_pkg::KIND_RECORD)
				records_checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	smlp_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	smlp_pkg::rsp_t rsp;

	map_scoreboard sb = new();
	smlp_pkg::req_t text_q[$];
	int bytes_sent = 0;
	int lines_built = 0;
	string ending = "";

	symbol_map_line_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Text generation helpers; everything lands in text_q.
	task automatic add_byte(logic [7:0] b);
		smlp_pkg::req_t item;
		item.byte_req = b;
		item.end_of_file = 1'b0;
		text_q.push_back(item);
	endtask

	task automatic add_eof();
		smlp_pkg::req_t item;
		item.byte_req = 8'($urandom_range(0, 255));
		item.end_of_file = 1'b1;
		text_q.push_back(item);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_name_char();
		int unsigned k;
		k = $urandom_range(0, 62);
		if (k < 26)
			return 8'("a" + k);
		if (k < 52)
			return 8'("A" + (k - 26));
		if (k < 62)
			return 8'("0" + (k - 52));
		return "_";
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int unsigned v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'("0" + v);
		return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + (v - 10));
	endfunction

	// First byte after the address: never a hex digit or a newline.
	function automatic logic [7:0] rest_opener();
		case ($urandom_range(0, 2))
		0: return smlp_pkg::CH_SPACE;
		1: return 8'(8'h80 + $urandom_range(0, 127));
		default: return 8'("g" + $urandom_range(0, 19));
		endcase
	endfunction

	function automatic logic [7:0] rest_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == smlp_pkg::CH_LF);
		return b;
	endfunction

	task automatic add_name(int len);
		repeat (len)
			add_byte(rand_name_char());
	endtask

	task automatic add_blanks(int n);
		repeat (n)
			add_byte(($urandom_range(0, 1) != 0) ? smlp_pkg::CH_TAB : smlp_pkg::CH_SPACE);
	endtask

	task automatic add_record_line();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			len = $urandom_range(1, 10);
		else if (pick < 95)
			len = $urandom_range(11, 60);
		else if (pick < 97)
			len = $urandom_range(100, smlp_pkg::MAX_NAME_LEN - 2);
		else
			len = smlp_pkg::MAX_NAME_LEN - 1;
		add_name(len);
		add_blanks($urandom_range(0, 3));
		add_text("= $");
		repeat ($urandom_range(0, 7))
			add_byte(rand_hex_char());
		if ($urandom_range(0, 1) != 0) begin
			add_byte(rest_opener());
			repeat ($urandom_range(0, 6))
				add_byte(rest_byte());
		end
		add_byte(smlp_pkg::CH_LF);
		lines_built++;
	endtask

	// Sender: bursts of random length separated by random gaps.
	task automatic send_text();
		smlp_pkg::req_t item;
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 24);
		while (text_q.size() > 0) begin
			item = text_q.pop_front();
			req <= item;
			req_valid <= 1'b1;
			do
				@(posedge clk);
			while (!req_ready);
			sb.note_byte(item);
			bytes_sent++;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		req_valid <= 1'b0;
	endtask

	// Receiver: switches between random stall patterns, and once
	// holds off long enough for the parser to back up into its input.
	initial begin : result_side
		int mode;
		int mode_left;
		int hold_left;
		int phase_cnt;
		bit held;
		mode_left = 0;
		hold_left = 0;
		phase_cnt = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			phase_cnt++;
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else if (!held && bytes_sent >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = LONG_HOLD - 1;
				rsp_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 80);
				end
				mode_left--;
				case (mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= (phase_cnt % 3) != 0;
				2: rsp_ready <= $urandom_range(0, 3) != 0;
				default: rsp_ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("symbol_map_line_parser regression: fail");
		$finish;
	end

	initial begin : main_seq
		logic [7:0] b;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: a one-character name with '=' right after it and an
		// empty address, then mixed blanks, a wrapping address in mixed case and
		// a rest of line holding the byte extremes.
		add_text("a= $\n");
		add_text("Z9_ \t= $1aB2c");
		add_byte(8'hFF);
		add_byte(8'h00);
		add_byte(smlp_pkg::CH_LF);
		lines_built += 2;

		while (text_q.size() < TEXT_BYTES)
			add_record_line();

		// Only one way to end loading fits in a run, so the seed picks it.
		case ($urandom_range(0, 5))
		0: begin
			add_eof();
			ending = "end of file at a line start";
		end
		1: begin
			do
				b = 8'($urandom_range(0, 255));
			while (map_scoreboard::is_name_char(b));
			add_byte(b);
			ending = "a non-name byte at a line start";
		end
		2: begin
			add_name(smlp_pkg::MAX_NAME_LEN);
			ending = "a name one character too long";
		end
		3: begin
			add_name($urandom_range(1, 8));
			case ($urandom_range(0, 6))
			0: add_eof();
			1: begin
				add_blanks($urandom_range(1, 3));
				add_byte(rand_name_char());
			end
			2: add_byte(($urandom_range(0, 1) != 0) ? smlp_pkg::CH_LF : smlp_pkg::CH_DOLLAR);
			3: begin
				add_byte(smlp_pkg::CH_EQUAL);
				add_byte(smlp_pkg::CH_TAB);
			end
			4: begin
				add_byte(smlp_pkg::CH_EQUAL);
				add_eof();
			end
			5: begin
				add_text("= ");
				add_byte(rand_name_char());
			end
			default: begin
				add_text("= ");
				add_eof();
			end
			endcase
			ending = "a malformed separator";
		end
		4: begin
			add_name($urandom_range(1, 8));
			add_text("= $");
			repeat ($urandom_range(0, 5))
				add_byte(rand_hex_char());
			add_eof();
			ending = "end of file inside an address";
		end
		default: begin
			add_name($urandom_range(1, 8));
			add_text("= $");
			add_byte(rand_hex_char());
			add_byte(rest_opener());
			repeat ($urandom_range(0, 3))
				add_byte(rest_byte());
			add_eof();
			ending = "end of file in the rest of a line";
		end
		endcase

		// A few beats after loading has stopped; none of them may produce anything.
		repeat ($urandom_range(4, 10)) begin
			b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 1) != 0)
				add_eof();
			else
				add_byte(b);
		end

		send_text();
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d text bytes over %0d map lines ending with %s.",
			bytes_sent, lines_built, ending);
		$display("Checked %0d result beats, %0d of them records; %0d mismatches.",
			sb.results_checked, sb.records_checked, sb.fails);
		if (sb.fails == 0 && sb.owed.size() == 0)
			$display("symbol_map_line_parser regression: pass");
		else
			$display("symbol_map_line_parser regression: fail");
		$finish;
	end

endmodule

// ----- symbol_map_line_parser.f -----
rtl/smlp_pkg.sv
rtl/symbol_map_line_parser.sv
sim/tb_symbol_map_line_parser.sv
